// ----- hw/rtl/bsxc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stuffer package
// Shared constants, types and the escape function of the byte stuffer.
// ----------------------------------------------------------------------------
package bsxc_pkg;

    // Number of header bytes at the start of a frame that stay out of the check.
    localparam int HEADER_BYTES = 3;
    localparam int HDR_POS_W    = 2;

    // Escaping codes.
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] FLAG_SUB  = 8'h5E;
    localparam logic [7:0] ESC_SUB   = 8'h5D;

    // At most two escaped bytes for the data and two for the check byte.
    localparam int MAX_RESULTS = 4;
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Escaped form of one byte: one or two bytes.
    typedef struct packed {
        logic       two;
        logic [7:0] first;
        logic [7:0] second;
    } esc_t;

    // Output sequence produced by one accepted item.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
        logic                        has_check;
    } bsxc_seq_t;

    function automatic esc_t escape_byte(input logic [7:0] b);
        esc_t e;
        e.two    = 1'b0;
        e.first  = b;
        e.second = b;
        if (b == FLAG_BYTE)
        begin
            e.two    = 1'b1;
            e.first  = ESC_BYTE;
            e.second = FLAG_SUB;
        end
        else if (b == ESC_BYTE)
        begin
            e.two    = 1'b1;
            e.first  = ESC_BYTE;
            e.second = ESC_SUB;
        end
        return e;
    endfunction

endpackage

// ----- hw/rtl/bsxc_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stuffer input channel
// Valid/ready channel carrying one frame byte and its end-of-frame flag.
// ----------------------------------------------------------------------------
interface bsxc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

// ----- hw/rtl/bsxc_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stuffer output channel
// Valid/ready channel carrying one stuffed byte and its end markers.
// ----------------------------------------------------------------------------
interface bsxc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_last;

    modport source (output valid, output out_byte, output run_last, output frame_last,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input frame_last,
                    output ready);
endinterface

// ----- hw/rtl/byte_stuffer_with_xor_check_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stuffer with XOR check
// Escapes frame bytes and appends an escaped XOR check byte to each frame.
// ----------------------------------------------------------------------------
// Usage:
// Frame bytes enter on in_ch, one per item, with frame_end set on the final
// byte. The first three bytes of a frame are escaped but kept out of the check.
// Stuffed bytes leave on out_ch, one per item: 0x7E and 0x7D go out as two
// bytes, and after the final byte the XOR check byte follows, escaped the same
// way. run_last marks the last output byte caused by an input item and
// frame_last marks the last byte of the frame.
// An accepted item is captured in the work register, and its first output
// byte then moves into the output register when that register is free or
// out_ch is ready. Throughput: one output byte per cycle while out_ch is
// ready, set by the single-byte output register, so an item of one to four
// bytes is sent one byte at a time; plain payload bytes flow at one item per
// cycle while out_ch is ready.
// The input takes a new item in the same cycle the last byte of the previous
// one moves into the output register, so a stall on out_ch backs up into in_ch
// after one buffered item. Reset clears the frame position, the check byte and
// all valid flags.
// ----------------------------------------------------------------------------
module byte_stuffer_with_xor_check_top
    import bsxc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bsxc_in_if.sink   in_ch,
    bsxc_out_if.source out_ch
);

    bsxc_seq_t        new_seq;
    bsxc_seq_t        work_reg;
    logic             work_valid_reg;
    logic             work_valid_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             run_last_reg;
    logic             frame_last_reg;
    logic             in_accept;
    logic             out_load;
    logic             is_last;

    // Sequence builder for the incoming item.
    bsxc_frame_builder u_builder (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .data_byte (in_ch.data_byte),
        .frame_end (in_ch.frame_end),
        .seq       (new_seq)
    );

    // Handshake control between the work register and the output register.
    always_comb
    begin
        is_last      = (CNT_W'(idx_reg) + CNT_W'(1)) == work_reg.count;
        out_load     = work_valid_reg && (!out_valid_reg || out_ch.ready);
        in_ch.ready  = !work_valid_reg || (out_load && is_last);
        in_accept    = in_ch.valid && in_ch.ready;
    end

    // Next values of the control registers.
    always_comb
    begin
        work_valid_next = work_valid_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 1'b1;
            if (is_last)
            begin
                work_valid_next = 1'b0;
            end
        end
        if (in_accept)
        begin
            work_valid_next = 1'b1;
            idx_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            work_reg <= new_seq;
        end
        if (out_load)
        begin
            out_byte_reg   <= work_reg.bytes[idx_reg];
            run_last_reg   <= is_last;
            frame_last_reg <= is_last && work_reg.has_check;
        end
    end

    // Output channel.
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_byte   = out_byte_reg;
    assign out_ch.run_last   = run_last_reg;
    assign out_ch.frame_last = frame_last_reg;

`ifndef SYNTHESIS
    // The frame end marker only sits on the last byte of an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.frame_last) |-> out_ch.run_last)
        else $error("frame_last without run_last");

    // A held sequence has between one and four bytes and the index stays inside it.
    assert property (@(posedge clk) disable iff (!rst_n)
        work_valid_reg |-> (work_reg.count >= CNT_W'(1) && work_reg.count <= CNT_W'(MAX_RESULTS)
                            && CNT_W'(idx_reg) < work_reg.count))
        else $error("work sequence index out of range");

    // Moving out the last byte without a new item frees the work register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && is_last && !in_accept) |=> !work_valid_reg)
        else $error("work register not released");
`endif

endmodule

// ----- hw/rtl/bsxc_frame_builder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte stuffer frame builder
// Tracks header position and XOR check, and builds the escaped byte sequence
// of the incoming item.
// ----------------------------------------------------------------------------
module bsxc_frame_builder
    import bsxc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       frame_end,
    output bsxc_seq_t  seq
);

    logic [HDR_POS_W-1:0] header_position_reg;
    logic [HDR_POS_W-1:0] header_position_next;
    logic [7:0]           check_accumulator_reg;
    logic [7:0]           check_accumulator_next;
    logic                 in_header;
    logic [7:0]           check_byte;
    esc_t                 data_esc;
    esc_t                 check_esc;
    logic [CNT_W-1:0]     data_len;
    logic [CNT_W-1:0]     check_len;

    // Check value including this byte, and the escaped forms of both bytes.
    always_comb
    begin
        in_header  = header_position_reg < HDR_POS_W'(HEADER_BYTES);
        check_byte = in_header ? check_accumulator_reg : (check_accumulator_reg ^ data_byte);
        data_esc   = escape_byte(data_byte);
        check_esc  = escape_byte(check_byte);
        data_len   = data_esc.two ? CNT_W'(2) : CNT_W'(1);
        check_len  = check_esc.two ? CNT_W'(2) : CNT_W'(1);
    end

    // Pack the data bytes first, then the check bytes when the frame ends.
    always_comb
    begin
        seq.bytes[0] = data_esc.first;
        seq.bytes[1] = data_esc.two ? data_esc.second : check_esc.first;
        seq.bytes[2] = data_esc.two ? check_esc.first : check_esc.second;
        seq.bytes[3] = check_esc.second;
        seq.count    = frame_end ? (data_len + check_len) : data_len;
        seq.has_check = frame_end;
    end

    // Frame state update on each accepted item.
    always_comb
    begin
        header_position_next   = header_position_reg;
        check_accumulator_next = check_accumulator_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                header_position_next   = '0;
                check_accumulator_next = '0;
            end
            else
            begin
                header_position_next   = in_header ? (header_position_reg + 1'b1)
                                                   : header_position_reg;
                check_accumulator_next = check_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_position_reg   <= '0;
            check_accumulator_reg <= '0;
        end
        else
        begin
            header_position_reg   <= header_position_next;
            check_accumulator_reg <= check_accumulator_next;
        end
    end

endmodule
